[sv/mpfb_pkg.sv]
// Shared types and constants for the page framebuffer draw core.
`default_nettype none
package mpfb_pkg;
    localparam int MAX_COLUMNS = 128;
    localparam int MAX_PAGES   = 8;
    localparam int STORE_DEPTH = MAX_COLUMNS * MAX_PAGES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    typedef enum logic [2:0] {
        OP_FILL   = 3'd0,
        OP_PIXEL  = 3'd1,
        OP_RECT   = 3'd2,
        OP_BITMAP = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    // Command handed from front to back: one clipped block, a store-wide fill, a read or none.
    typedef enum logic [1:0] {
        CMD_BLOCK = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        last;   // final command of its item: back emits the result
        logic        ink;
        logic [7:0]  xs;     // clipped start column, inclusive
        logic [8:0]  xe;     // clipped end column, exclusive
        logic [6:0]  ys;
        logic [6:0]  ye;
        logic [10:0] ridx;   // read index, bit 10 marks out of range
    } cmd_t;

    typedef enum logic [1:0] {
        F_IDLE  = 2'd0,
        F_BITS  = 2'd1
    } fstate_t;

    typedef enum logic [2:0] {
        B_IDLE  = 3'd0,
        B_RD    = 3'd1,
        B_WAIT  = 3'd2,
        B_WR    = 3'd3,
        B_FILL  = 3'd4,
        B_RDRES = 3'd5,
        B_OUT   = 3'd6,
        B_CLR   = 3'd7
    } bstate_t;
endpackage
`default_nettype wire

[sv/mpfb_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module mpfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one address per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[sv/mpfb_front.sv]
// Front end: accepts items, clips them and issues block, fill and read commands.
`default_nettype none
module mpfb_front import mpfb_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  op,
    input  wire logic [8:0]  pos_x,
    input  wire logic [8:0]  pos_y,
    input  wire logic [8:0]  rect_width,
    input  wire logic [8:0]  rect_height,
    input  wire logic [5:0]  bitmap_row,
    input  wire logic [3:0]  byte_column,
    input  wire logic [7:0]  pattern,
    input  wire logic [3:0]  scale_x,
    input  wire logic [3:0]  scale_y,
    input  wire logic        ink,
    input  wire logic [9:0]  read_index,
    input  wire logic [8:0]  aw,
    input  wire logic [6:0]  ah,
    output logic             cmd_valid,
    input  wire logic        cmd_ready,
    output cmd_t             cmd
);
    fstate_t state_reg, state_next;
    // Latched bitmap item
    logic signed [13:0] bx_reg, bx_next;   // left column of current block
    logic signed [13:0] by_reg;
    logic [3:0]  sx_reg, sy_reg;
    logic [7:0]  pat_reg, pat_next;
    logic [3:0]  k_reg, k_next;
    logic        ink_reg;

    logic signed [13:0] row_prod;
    logic signed [13:0] col_prod;
    logic signed [13:0] cx0, cy0, cx1, cy1;
    logic signed [13:0] bw, bh;
    cmd_t blk;

    // Clip a block given origin and size
    function automatic cmd_t clip(input logic signed [13:0] x0, input logic signed [13:0] y0,
                                  input logic signed [13:0] w, input logic signed [13:0] h,
                                  input logic [8:0] wid, input logic [6:0] hgt,
                                  input logic ik);
        cmd_t c;
        logic signed [13:0] xs, xe, ys, ye;
        c = '0;
        xs = (x0 < 0) ? 14'sd0 : x0;
        xe = (x0 + w > $signed({5'd0, wid})) ? $signed({5'd0, wid}) : x0 + w;
        ys = (y0 < 0) ? 14'sd0 : y0;
        ye = (y0 + h > $signed({7'd0, hgt})) ? $signed({7'd0, hgt}) : y0 + h;
        c.ink = ik;
        if (xs < xe && ys < ye) begin
            c.kind = CMD_BLOCK;
            c.xs = xs[7:0];
            c.xe = xe[8:0];
            c.ys = ys[6:0];
            c.ye = ye[6:0];
        end else begin
            c.kind = CMD_NONE;
        end
        return c;
    endfunction

    // Bitmap block origin
    assign row_prod = $signed({8'd0, bitmap_row}) * $signed({10'd0, scale_y});
    assign col_prod = $signed({7'd0, byte_column, 3'd0}) * $signed({10'd0, scale_x});

    // Pick the block for the current cycle
    always_comb begin
        cx0 = $signed({{5{pos_x[8]}}, pos_x});
        cy0 = $signed({{5{pos_y[8]}}, pos_y});
        bw  = 14'sd1;
        bh  = 14'sd1;
        if (state_reg == F_BITS) begin
            cx0 = bx_reg;
            cy0 = by_reg;
            bw  = $signed({10'd0, sx_reg});
            bh  = $signed({10'd0, sy_reg});
        end else if (op == OP_RECT) begin
            bw = $signed({5'd0, rect_width});
            bh = $signed({5'd0, rect_height});
        end
        cx1 = cx0;
        cy1 = cy0;
        blk = clip(cx1, cy1, bw, bh, aw, ah, (state_reg == F_BITS) ? ink_reg : ink);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_valid && op == OP_BITMAP) begin
                    state_next = F_BITS;
                end
            end
            F_BITS: begin
                // Final bit slot always offers a word; leave once it is taken
                if (k_reg == 4'd8) begin
                    state_next = F_IDLE;
                end else if (k_reg == 4'd7 && cmd_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        in_ready  = 1'b0;
        cmd_valid = 1'b0;
        cmd       = blk;
        cmd.last  = 1'b1;
        cmd.ridx  = '0;
        bx_next   = bx_reg;
        pat_next  = pat_reg;
        k_next    = k_reg;
        case (state_reg)
            F_IDLE: begin
                case (op)
                    OP_FILL: begin
                        cmd.kind = CMD_FILL;
                        cmd_valid = in_valid;
                        in_ready = cmd_ready;
                    end
                    OP_PIXEL, OP_RECT: begin
                        cmd_valid = in_valid;
                        in_ready = cmd_ready;
                    end
                    OP_READ: begin
                        cmd.kind = CMD_READ;
                        cmd.ridx = {1'b0, read_index};
                        cmd_valid = in_valid;
                        in_ready = cmd_ready;
                    end
                    OP_BITMAP: begin
                        in_ready = 1'b1;
                        bx_next = $signed({{5{pos_x[8]}}, pos_x}) + col_prod;
                        pat_next = pattern;
                        k_next = 4'd0;
                    end
                    default: begin
                        cmd.kind = CMD_NONE;
                        cmd_valid = in_valid;
                        in_ready = cmd_ready;
                    end
                endcase
            end
            F_BITS: begin
                // Emit one block per set bit whose block survives clipping; final slot carries the result
                cmd.last = (k_reg == 4'd7) || (k_reg == 4'd8);
                if (k_reg == 4'd8) begin
                    cmd.kind = CMD_NONE;
                    cmd_valid = 1'b1;
                end else if (pat_reg[7]) begin
                    cmd_valid = 1'b1;
                    if (cmd.last == 1'b0 && blk.kind == CMD_NONE) cmd_valid = 1'b0;
                end else if (k_reg == 4'd7) begin
                    cmd.kind = CMD_NONE;
                    cmd_valid = 1'b1;
                end
                if (!cmd_valid || cmd_ready) begin
                    k_next = k_reg + 4'd1;
                    pat_next = {pat_reg[6:0], 1'b0};
                    bx_next = bx_reg + $signed({10'd0, sx_reg});
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bx_reg  <= bx_next;
        pat_reg <= pat_next;
        k_reg   <= k_next;
        if (state_reg == F_IDLE && in_valid && op == OP_BITMAP) begin
            by_reg  <= $signed({{5{pos_y[8]}}, pos_y}) + row_prod;
            sx_reg  <= scale_x;
            sy_reg  <= scale_y;
            ink_reg <= ink;
        end
    end
endmodule
`default_nettype wire

[sv/mpfb_queue.sv]
// Short command queue between front and back.
`default_nettype none
module mpfb_queue import mpfb_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  cmd_t      wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output cmd_t      rd_data
);
    cmd_t       slot_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 3'd4);
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data  = slot_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop)  rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
        if (push) slot_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

[sv/mpfb_back.sv]
// Back end: clears and fills the store, runs read-modify-write sweeps and returns results.
`default_nettype none
module mpfb_back import mpfb_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  cmd_t             cmd,
    input  wire logic [8:0]  aw,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_data
);
    bstate_t state_reg, state_next;
    cmd_t    c_reg;
    logic [7:0]        x_reg;
    logic [6:0]        y_reg;
    logic [ADDR_W:0]   fa_reg;
    logic [7:0]        res_reg;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata, rdata, mask;
    logic [13:0]       lin;

    assign lin  = {10'd0, y_reg[6:3]} * {5'd0, aw} + {6'd0, x_reg};
    assign mask = 8'd1 << y_reg[2:0];

    mpfb_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram (
        .aclk (aclk),
        .we   (we),
        .addr (addr),
        .wdata(wdata),
        .rdata(rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_CLR:  if (fa_reg == (ADDR_W+1)'(STORE_DEPTH - 1)) state_next = B_IDLE;
            B_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        CMD_BLOCK: state_next = B_RD;
                        CMD_FILL:  state_next = B_FILL;
                        CMD_READ:  state_next = B_RDRES;
                        default:   state_next = cmd.last ? B_OUT : B_IDLE;
                    endcase
                end
            end
            B_RD:   state_next = B_WAIT;
            B_WAIT: state_next = B_WR;
            B_WR: begin
                if ({1'b0, x_reg} + 9'd1 < c_reg.xe) state_next = B_RD;
                else if (y_reg + 7'd1 < c_reg.ye) state_next = B_RD;
                else state_next = c_reg.last ? B_OUT : B_IDLE;
            end
            B_FILL: if (fa_reg == (ADDR_W+1)'(STORE_DEPTH - 1)) state_next = B_OUT;
            B_RDRES: state_next = B_OUT;
            B_OUT:  if (out_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd_ready = (state_reg == B_IDLE);
        out_valid = (state_reg == B_OUT);
        out_data  = res_reg;
        we    = 1'b0;
        addr  = lin[ADDR_W-1:0];
        wdata = c_reg.ink ? (rdata | mask) : (rdata & ~mask);
        case (state_reg)
            B_CLR: begin
                we = 1'b1; addr = fa_reg[ADDR_W-1:0]; wdata = 8'h00;
            end
            B_FILL: begin
                we = 1'b1; addr = fa_reg[ADDR_W-1:0];
                wdata = c_reg.ink ? 8'hFF : 8'h00;
            end
            B_WR: we = (lin < 14'(STORE_DEPTH));
            B_IDLE: addr = cmd.ridx[ADDR_W-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_CLR;
            fa_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_CLR || state_reg == B_FILL) fa_reg <= fa_reg + (ADDR_W+1)'(1);
            else fa_reg <= '0;
        end
        if (cmd_valid && cmd_ready) begin
            c_reg   <= cmd;
            x_reg   <= cmd.xs;
            y_reg   <= cmd.ys;
            res_reg <= 8'h00;
        end
        // Step columns, then rows
        if (state_reg == B_WR) begin
            if ({1'b0, x_reg} + 9'd1 < c_reg.xe) begin
                x_reg <= x_reg + 8'd1;
            end else begin
                x_reg <= c_reg.xs;
                y_reg <= y_reg + 7'd1;
            end
        end
        if (state_reg == B_RDRES) begin
            res_reg <= (c_reg.ridx < 11'(STORE_DEPTH)) ? rdata : 8'h00;
        end
    end
endmodule
`default_nettype wire

[sv/mono_page_framebuffer_draw_core.sv]
// Top level of the page framebuffer draw core.
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: draw or read item
//  m_      | out | m_tvalid/m_tready  | m_tdata: read_data
//  cfg     | in  | cfg_we             | cfg_index, cfg_wdata
// Each touched pixel takes a read, a wait and a write of its byte in the single-port
// store, and each item is accepted once and returns one result word; a bitmap byte
// steps through its eight bit slots in the front; fill all writes every store address.
// After reset all STORE_DEPTH (1024) store addresses are cleared; items queue meanwhile.
// Front and back stall independently across a four-entry command queue.
`default_nettype none
module mono_page_framebuffer_draw_core import mpfb_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op[2:0], pos_x[11:3], pos_y[20:12], rect_width[29:21], rect_height[38:30],
    // bitmap_row[44:39], byte_column[48:45], pattern[56:49], scale_x[60:57],
    // scale_y[64:61], ink[65], read_index[75:66]
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data[7:0]
    output logic [7:0]       m_tdata,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata
);
    logic [7:0] awr_reg;
    logic [6:0] ahr_reg;
    logic [8:0] aw;
    logic [6:0] ah;
    logic       fq_valid, fq_ready, qb_valid, qb_ready;
    cmd_t       fq_cmd, qb_cmd;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awr_reg <= 8'd128;
            ahr_reg <= 7'd64;
        end else if (cfg_we) begin
            if (cfg_index == REG_WIDTH) awr_reg <= cfg_wdata;
            else ahr_reg <= cfg_wdata[6:0];
        end
    end

    // Effective sizes
    always_comb begin
        aw = (awr_reg == 8'd0) ? 9'd1 : {1'b0, awr_reg};
        if (aw > 9'(MAX_COLUMNS)) aw = 9'(MAX_COLUMNS);
        ah = {ahr_reg[6:3], 3'd0};
        if (ah < 7'd8) ah = 7'd8;
        if (ah > 7'(MAX_PAGES * 8)) ah = 7'(MAX_PAGES * 8);
    end

    mpfb_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .op(s_tdata[2:0]), .pos_x(s_tdata[11:3]), .pos_y(s_tdata[20:12]),
        .rect_width(s_tdata[29:21]), .rect_height(s_tdata[38:30]),
        .bitmap_row(s_tdata[44:39]), .byte_column(s_tdata[48:45]),
        .pattern(s_tdata[56:49]), .scale_x(s_tdata[60:57]), .scale_y(s_tdata[64:61]),
        .ink(s_tdata[65]), .read_index(s_tdata[75:66]),
        .aw(aw), .ah(ah),
        .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
    );

    mpfb_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_cmd),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_cmd)
    );

    mpfb_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
        .aw(aw),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );

    // A result word holds steady while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    // A full queue always offers a command to the back
    a_queue_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !fq_ready |-> !(qb_ready && !qb_valid))
        else $error("queue flow inconsistent");
    // Back takes no command while a result waits
    a_back_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !qb_ready)
        else $error("back accepted while result pending");
endmodule
`default_nettype wire
